[design/mffu_pkg.sv]
package mffu_pkg;

  // Widths of stream, fields and state
  localparam int WORD_W          = 32;
  localparam int FIELD_W         = 16;
  localparam int MAX_FIELD_WIDTH = 16;
  localparam int CNT_W           = 8;
  localparam int WSEL_W          = 5;
  localparam int BUF_W           = 48;
  localparam int HELD_W          = 6;
  localparam int ADDR_W          = 5;
  localparam int DATA_W          = 32;

  // Register indexes (paddr[4:2])
  localparam logic [2:0] REG_WIDTH_A = 3'd0;
  localparam logic [2:0] REG_COUNT_A = 3'd1;
  localparam logic [2:0] REG_WIDTH_B = 3'd2;
  localparam logic [2:0] REG_COUNT_B = 3'd3;
  localparam logic [2:0] REG_SLOT    = 3'd4;

  // Reset values of the registers
  localparam logic [WSEL_W-1:0] WIDTH_A_RST = 5'd12;
  localparam logic [CNT_W-1:0]  COUNT_A_RST = 8'd63;
  localparam logic [WSEL_W-1:0] WIDTH_B_RST = 5'd2;
  localparam logic [CNT_W-1:0]  COUNT_B_RST = 8'd63;

  typedef struct packed {
    logic [WSEL_W-1:0] width_a;
    logic [CNT_W-1:0]  count_a;
    logic [WSEL_W-1:0] width_b;
    logic [CNT_W-1:0]  count_b;
    logic [CNT_W-1:0]  record_slot;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // take the accepted word into the bit buffer
    logic step;   // extract one field into the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;   // output register can take a field this cycle
    logic empty_rec;  // both counts are zero
    logic last;       // the field extracted now ends this word's work
  } dp_stat_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXTRACT
  } state_t;

  // Width 0 acts as 1, widths above the maximum saturate
  function automatic logic [WSEL_W-1:0] eff_width(input logic [WSEL_W-1:0] w);
    logic [WSEL_W-1:0] r;
    if (w == '0) begin
      r = WSEL_W'(1);
    end else if (w > WSEL_W'(MAX_FIELD_WIDTH)) begin
      r = WSEL_W'(MAX_FIELD_WIDTH);
    end else begin
      r = w;
    end
    return r;
  endfunction

endpackage

[design/mffu_regs.sv]
module mffu_regs
  import mffu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg,
  output logic              restart
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width_a     <= WIDTH_A_RST;
      cfg.count_a     <= COUNT_A_RST;
      cfg.width_b     <= WIDTH_B_RST;
      cfg.count_b     <= COUNT_B_RST;
      cfg.record_slot <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_WIDTH_A: cfg.width_a     <= pwdata[WSEL_W-1:0];
        REG_COUNT_A: cfg.count_a     <= pwdata[CNT_W-1:0];
        REG_WIDTH_B: cfg.width_b     <= pwdata[WSEL_W-1:0];
        REG_COUNT_B: cfg.count_b     <= pwdata[CNT_W-1:0];
        REG_SLOT:    cfg.record_slot <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Shape writes abandon the record in progress
  always_comb begin
    restart = 1'b0;
    if (wr_en) begin
      case (idx)
        REG_WIDTH_A, REG_COUNT_A, REG_WIDTH_B, REG_COUNT_B: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  // Read decode
  always_comb begin
    unique case (idx)
      REG_WIDTH_A: prdata = DATA_W'(cfg.width_a);
      REG_COUNT_A: prdata = DATA_W'(cfg.count_a);
      REG_WIDTH_B: prdata = DATA_W'(cfg.width_b);
      REG_COUNT_B: prdata = DATA_W'(cfg.count_b);
      REG_SLOT:    prdata = DATA_W'(cfg.record_slot);
      default:     prdata = '0;
    endcase
  end

endmodule

[design/mffu_ctrl.sv]
module mffu_ctrl
  import mffu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!stat.empty_rec) begin
            state_next = ST_EXTRACT;
          end
        end
      end
      ST_EXTRACT: begin
        if (stat.out_free) begin
          cmd.step = 1'b1;
          if (stat.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[design/mffu_dp.sv]
module mffu_dp
  import mffu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               restart,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic [WORD_W-1:0]  word,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FIELD_W-1:0] field_value,
  output logic               section,
  output logic [CNT_W-1:0]   field_index,
  output logic [CNT_W-1:0]   slot,
  output logic               last,
  output logic               record_done
);

  logic [BUF_W-1:0]  bit_buffer;
  logic [HELD_W-1:0] bits_held;
  logic              in_section_b;
  logic [CNT_W-1:0]  field_count;

  logic [WSEL_W-1:0] w_cur, w_next, w_b;
  logic [CNT_W-1:0]  cnt_cur;
  logic [HELD_W-1:0] held_new;
  logic [BUF_W-1:0]  shifted, buf_masked;
  logic [FIELD_W-1:0] val;
  logic [CNT_W:0]    fc_inc;
  logic              sec_end, to_b, done, is_last;

  // Field extraction from the top of the held bits
  always_comb begin
    w_b        = eff_width(cfg.width_b);
    w_cur      = in_section_b ? w_b : eff_width(cfg.width_a);
    cnt_cur    = in_section_b ? cfg.count_b : cfg.count_a;
    held_new   = bits_held - HELD_W'(w_cur);
    shifted    = bit_buffer >> held_new;
    val        = shifted[FIELD_W-1:0] & ~({FIELD_W{1'b1}} << w_cur);
    buf_masked = bit_buffer & ~({BUF_W{1'b1}} << held_new);
    fc_inc     = {1'b0, field_count} + (CNT_W+1)'(1);
    sec_end    = fc_inc >= {1'b0, cnt_cur};
    to_b       = sec_end && !in_section_b && (cfg.count_b != '0);
    done       = sec_end && !to_b;
    w_next     = to_b ? w_b : w_cur;
    is_last    = done || (held_new < HELD_W'(w_next));
  end

  assign stat.out_free  = !out_valid || !out_stall;
  assign stat.empty_rec = (cfg.count_a == '0) && (cfg.count_b == '0);
  assign stat.last      = is_last;

  // Record state
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      bit_buffer   <= '0;
      bits_held    <= '0;
      in_section_b <= 1'b0;
      field_count  <= '0;
    end else if (cmd.load) begin
      if (stat.empty_rec) begin
        bit_buffer   <= '0;
        bits_held    <= '0;
        in_section_b <= 1'b0;
        field_count  <= '0;
      end else begin
        bit_buffer <= {bit_buffer[BUF_W-WORD_W-1:0], word};
        bits_held  <= bits_held + HELD_W'(WORD_W);
        // empty section A is skipped at the first word
        if (!in_section_b && (field_count >= cfg.count_a)) begin
          in_section_b <= 1'b1;
          field_count  <= '0;
        end
      end
    end else if (cmd.step) begin
      if (done) begin
        bit_buffer   <= '0;
        bits_held    <= '0;
        in_section_b <= 1'b0;
        field_count  <= '0;
      end else begin
        bit_buffer <= buf_masked;
        bits_held  <= held_new;
        if (to_b) begin
          in_section_b <= 1'b1;
          field_count  <= '0;
        end else begin
          field_count <= fc_inc[CNT_W-1:0];
        end
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output beat payload
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      field_value <= val;
      section     <= in_section_b;
      field_index <= field_count;
      slot        <= cfg.record_slot;
      last        <= is_last;
      record_done <= done;
    end
  end

endmodule

[design/msb_first_field_unpacker.sv]
// MSB-first field unpacker.
// Input channel: in_valid / in_stall with one 32-bit stream word per beat.
// Output channel: out_valid / out_stall with one unpacked field per beat,
// carrying field_value, section, field_index, slot, last and record_done.
// Each word yields every field it completes, in stream order; last marks the
// final field of that word and record_done the final field of the record.
// Leftover bits after record_done are dropped; the next word starts a record.
// Flow: a word is loaded into the bit buffer, then the extraction loop emits
// one field per cycle into the output register while the output is free, so
// a word stays in the block until all of its fields (up to 32 for 1-bit fields,
// sixteen for 2-bit) are extracted. No new word is taken during extraction.
// A word is accepted while the previous last field still waits at the output.
// When the receiver stalls, the output register holds its beat and extraction
// pauses. A word with both counts zero is dropped with no output beat.
// Reset (rst, synchronous) restores the default register values and clears
// the bit buffer; writing any width or count register also clears it.
// Configuration: APB registers at 0x0 width_a, 0x4 count_a, 0x8 width_b,
// 0xC count_b, 0x10 record_slot.
module msb_first_field_unpacker
  import mffu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [WORD_W-1:0]  word,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FIELD_W-1:0] field_value,
  output logic               section,
  output logic [CNT_W-1:0]   field_index,
  output logic [CNT_W-1:0]   slot,
  output logic               last,
  output logic               record_done
);

  cfg_t     cfg;
  logic     restart;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  mffu_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .restart (restart)
  );

  mffu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mffu_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .restart     (restart),
    .cmd         (cmd),
    .stat        (stat),
    .word        (word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .field_value (field_value),
    .section     (section),
    .field_index (field_index),
    .slot        (slot),
    .last        (last),
    .record_done (record_done)
  );

endmodule

[tb/msb_first_field_unpacker_tb.sv]
`timescale 1ns / 1ps

module msb_first_field_unpacker_tb;
  import mffu_pkg::*;

  localparam int RAND_WORDS    = 160;
  localparam int SETTLE_CYCLES = 40;   // longest word (32 fields) plus margin
  localparam int ADDR_SLOTS    = 8;    // register indexes reachable through paddr
  localparam int WORD_FIELDS   = 32;   // most fields one word can complete

  // one expected output beat
  typedef struct {
    logic [FIELD_W-1:0] value;
    logic               sect;
    logic [CNT_W-1:0]   index;
    logic [CNT_W-1:0]   slot_no;
    logic               word_end;
    logic               rec_end;
  } field_beat_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic [WORD_W-1:0]  word;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [FIELD_W-1:0] field_value;
  logic               section;
  logic [CNT_W-1:0]   field_index;
  logic [CNT_W-1:0]   slot;
  logic               last;
  logic               record_done;

  msb_first_field_unpacker dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .word        (word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .field_value (field_value),
    .section     (section),
    .field_index (field_index),
    .slot        (slot),
    .last        (last),
    .record_done (record_done)
  );

  // Unpacker model: registers and record state
  logic [WSEL_W-1:0] cfg_width_a;
  logic [CNT_W-1:0]  cfg_count_a;
  logic [WSEL_W-1:0] cfg_width_b;
  logic [CNT_W-1:0]  cfg_count_b;
  logic [CNT_W-1:0]  cfg_slot;
  logic [63:0]       held_bits;
  int                held_cnt;
  bit                in_b;
  int                fields_done;

  field_beat_t pending_fields[$];
  int          n_mismatch = 0;

  // receiver stall pattern controls
  bit stall_on = 1'b0;
  int stall_left = 0;
  int free_left = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("msb_first_field_unpacker_tb: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    n_mismatch++;
  endtask

  function automatic void restart_record();
    held_bits   = '0;
    held_cnt    = 0;
    in_b        = 1'b0;
    fields_done = 0;
  endfunction

  function automatic int field_bits(input logic [WSEL_W-1:0] w);
    if (w == '0) return 1;
    if (w > MAX_FIELD_WIDTH) return MAX_FIELD_WIDTH;
    return int'(w);
  endfunction

  function automatic logic [DATA_W-1:0] reg_value(input logic [2:0] idx);
    case (idx)
      REG_WIDTH_A: return DATA_W'(cfg_width_a);
      REG_COUNT_A: return DATA_W'(cfg_count_a);
      REG_WIDTH_B: return DATA_W'(cfg_width_b);
      REG_COUNT_B: return DATA_W'(cfg_count_b);
      REG_SLOT:    return DATA_W'(cfg_slot);
      default:     return '0;
    endcase
  endfunction

  // shape writes drop the record in progress, a slot write does not
  function automatic void apply_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    case (idx)
      REG_WIDTH_A: begin
        cfg_width_a = val[WSEL_W-1:0];
        restart_record();
      end
      REG_COUNT_A: begin
        cfg_count_a = val[CNT_W-1:0];
        restart_record();
      end
      REG_WIDTH_B: begin
        cfg_width_b = val[WSEL_W-1:0];
        restart_record();
      end
      REG_COUNT_B: begin
        cfg_count_b = val[CNT_W-1:0];
        restart_record();
      end
      REG_SLOT: cfg_slot = val[CNT_W-1:0];
      default: ;
    endcase
  endfunction

  // Expected fields for one accepted word
  function automatic void unpack_expect(input logic [WORD_W-1:0] w);
    int          ca;
    int          cb;
    int          wd;
    int          cnt;
    bit          fin;
    field_beat_t b;
    field_beat_t batch[$];
    ca = int'(cfg_count_a);
    cb = int'(cfg_count_b);
    if (ca == 0 && cb == 0) begin
      restart_record();
      return;
    end
    if (!in_b && fields_done >= ca) begin
      in_b = 1'b1;
      fields_done = 0;
    end
    held_bits = (held_bits << 32) | {32'b0, w};
    held_cnt += 32;
    while (1) begin
      wd  = field_bits(in_b ? cfg_width_b : cfg_width_a);
      cnt = in_b ? cb : ca;
      if (held_cnt < wd || batch.size() >= WORD_FIELDS) break;
      b.value    = FIELD_W'((held_bits >> (held_cnt - wd)) & ((64'd1 << wd) - 64'd1));
      held_cnt  -= wd;
      held_bits &= (64'd1 << held_cnt) - 64'd1;
      b.sect     = in_b;
      b.index    = CNT_W'(fields_done);
      b.slot_no  = cfg_slot;
      b.word_end = 1'b0;
      b.rec_end  = 1'b0;
      fields_done++;
      fin = 1'b0;
      if (fields_done >= cnt) begin
        if (!in_b && cb != 0) begin
          in_b = 1'b1;
          fields_done = 0;
        end else begin
          fin = 1'b1;
        end
      end
      if (fin) begin
        b.rec_end = 1'b1;
        batch.push_back(b);
        restart_record();
        break;
      end
      batch.push_back(b);
    end
    if (batch.size() > 0) batch[batch.size()-1].word_end = 1'b1;
    foreach (batch[i]) pending_fields.push_back(batch[i]);
  endfunction

  // Receiver: stall runs alternating with free runs
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (free_left > 0) begin
      out_stall <= 1'b0;
      free_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = stall_on ? $urandom_range(0, 5) : 0;
      free_left  = $urandom_range(0, 8);
    end
  end

  // Output beat checker
  field_beat_t head;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_fields.size() == 0) begin
        report_mismatch($sformatf("unexpected beat value=%0h sect=%0b idx=%0d",
                                  field_value, section, field_index));
      end else begin
        head = pending_fields.pop_front();
        if (field_value !== head.value)
          report_mismatch($sformatf("field_value got %0h want %0h", field_value, head.value));
        if (section !== head.sect)
          report_mismatch($sformatf("section got %0b want %0b", section, head.sect));
        if (field_index !== head.index)
          report_mismatch($sformatf("field_index got %0d want %0d", field_index, head.index));
        if (slot !== head.slot_no)
          report_mismatch($sformatf("slot got %0h want %0h", slot, head.slot_no));
        if (last !== head.word_end)
          report_mismatch($sformatf("last got %0b want %0b", last, head.word_end));
        if (record_done !== head.rec_end)
          report_mismatch($sformatf("record_done got %0b want %0b", record_done, head.rec_end));
      end
    end
  end

  // Drive one word and wait until it is accepted
  task automatic push_word(input logic [WORD_W-1:0] w);
    @(negedge clk);
    in_valid <= 1'b1;
    word     <= w;
    do @(posedge clk); while (in_stall);
    unpack_expect(w);
  endtask

  task automatic idle_for(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Hold off input until every predicted field is out, then let the block settle
  task automatic wait_quiet();
    idle_for(1);
    while (pending_fields.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [2:0] idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== reg_value(idx))
      report_mismatch($sformatf("prdata reg %0d got %0h want %0h", idx, prdata,
                                reg_value(idx)));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_shape(input logic [DATA_W-1:0] wa, input logic [DATA_W-1:0] ca,
                           input logic [DATA_W-1:0] wb, input logic [DATA_W-1:0] cb);
    apb_write(REG_WIDTH_A, wa);
    apb_write(REG_COUNT_A, ca);
    apb_write(REG_WIDTH_B, wb);
    apb_write(REG_COUNT_B, cb);
  endtask

  // Defaults after reset: register readback, then 12-bit fields
  task automatic test_defaults();
    for (int i = 0; i <= REG_SLOT; i++) apb_read_check(3'(i));
    stall_on = 1'b1;
    push_word(32'hFFFF_FFFF);
    push_word(32'h0000_0000);
    push_word(32'hA5A5_A5A5);
    wait_quiet();
  endtask

  // 1-bit fields: a full word of results, record ends on the word
  task automatic test_one_bit_fields();
    set_shape(1, 32, 2, 0);
    push_word(32'hFFFF_FFFF);
    push_word(32'h8000_0001);
    wait_quiet();
  endtask

  task automatic test_full_width();
    stall_on = 1'b0;
    set_shape(16, 3, 16, 1);
    push_word(32'hFFFF_0000);
    push_word(32'h8001_7FFE);
    wait_quiet();
  endtask

  // width 0 acts as 1, width above max saturates
  task automatic test_width_clamp();
    stall_on = 1'b1;
    set_shape(0, 3, 31, 2);
    push_word(32'hDEAD_BEEF);
    push_word(32'h0F0F_0F0F);
    wait_quiet();
  endtask

  task automatic test_skip_section_a();
    set_shape(12, 0, 5, 7);
    push_word(32'h1234_5678);
    push_word(32'h9ABC_DEF0);
    wait_quiet();
  endtask

  // both counts zero: words are dropped without output
  task automatic test_empty_record();
    set_shape(12, 0, 2, 0);
    push_word(32'hCAFE_F00D);
    push_word(32'h0123_4567);
    wait_quiet();
  endtask

  // slot change mid-record keeps the record going
  task automatic test_slot_rewrite();
    set_shape(12, 10, 3, 0);
    apb_write(REG_SLOT, 32'h5A);
    push_word(32'h8765_4321);
    wait_quiet();
    apb_write(REG_SLOT, 32'hFF);
    push_word(32'hFEDC_BA98);
    push_word(32'h7654_3210);
    push_word(32'h5555_AAAA);
    wait_quiet();
  endtask

  // rewriting a shape register drops leftover bits
  task automatic test_shape_rewrite();
    push_word(32'hABCD_EF01);
    wait_quiet();
    apb_write(REG_COUNT_A, 10);
    push_word(32'h2345_6789);
    wait_quiet();
  endtask

  // writes past the last register change nothing
  task automatic test_bad_index();
    for (int i = REG_SLOT + 1; i < ADDR_SLOTS; i++) apb_write(3'(i), $urandom);
    for (int i = 0; i <= REG_SLOT; i++) apb_read_check(3'(i));
    push_word(32'h3C3C_C3C3);
    wait_quiet();
  endtask

  function automatic logic [DATA_W-1:0] rand_width();
    logic [DATA_W-1:0] v;
    v = $urandom & ~32'h1F;
    if ($urandom_range(0, 4) == 0) v[WSEL_W-1:0] = WSEL_W'($urandom_range(0, 31));
    else v[WSEL_W-1:0] = WSEL_W'($urandom_range(1, MAX_FIELD_WIDTH));
    return v;
  endfunction

  function automatic logic [DATA_W-1:0] rand_count(input int hi);
    logic [DATA_W-1:0] v;
    v = $urandom & ~32'hFF;
    if ($urandom_range(0, 7) == 0) v[CNT_W-1:0] = 0;
    else v[CNT_W-1:0] = CNT_W'($urandom_range(1, hi));
    return v;
  endfunction

  // Random phases: new settings, then bursts of words with gaps
  task automatic test_random_phases();
    int sent;
    int phase;
    int n_words;
    int burst;
    bit gappy;
    logic [WORD_W-1:0] w;
    sent  = 0;
    phase = 0;
    while (sent < RAND_WORDS) begin
      wait_quiet();
      case ($urandom_range(0, 7))
        0: apb_write(REG_SLOT, $urandom);
        1: begin
          set_shape($urandom_range(0, 3) == 0 ? 31 : ($urandom_range(0, 1) ? 1 : 16),
                    $urandom_range(0, 1) ? 255 : 1,
                    $urandom_range(0, 1) ? 0 : 16,
                    $urandom_range(0, 1) ? 255 : 0);
          apb_write(REG_SLOT, $urandom_range(0, 1) ? 32'hFF : 32'h0);
        end
        default: begin
          set_shape(rand_width(), rand_count(10), rand_width(), rand_count(12));
          apb_write(REG_SLOT, $urandom);
        end
      endcase
      stall_on = ($urandom_range(0, 3) != 0);
      gappy    = ($urandom_range(0, 3) != 0);
      n_words  = $urandom_range(4, 20);
      while (n_words > 0 && sent < RAND_WORDS) begin
        burst = $urandom_range(1, 8);
        while (burst > 0 && n_words > 0 && sent < RAND_WORDS) begin
          case ($urandom_range(0, 9))
            0: w = '0;
            1: w = '1;
            default: w = $urandom;
          endcase
          push_word(w);
          burst--;
          n_words--;
          sent++;
        end
        // in phase 2 the sender holds off until every field is out
        if (phase == 2 && n_words > 0) wait_quiet();
        else if (gappy) idle_for($urandom_range(1, 6));
      end
      phase++;
    end
  endtask

  initial begin
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    word     = '0;
    cfg_width_a = WIDTH_A_RST;
    cfg_count_a = COUNT_A_RST;
    cfg_width_b = WIDTH_B_RST;
    cfg_count_b = COUNT_B_RST;
    cfg_slot    = '0;
    restart_record();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_defaults();
    test_one_bit_fields();
    test_full_width();
    test_width_clamp();
    test_skip_section_a();
    test_empty_record();
    test_slot_rewrite();
    test_shape_rewrite();
    test_bad_index();
    test_random_phases();
    wait_quiet();

    if (n_mismatch == 0) begin
      $display("msb_first_field_unpacker_tb: done, clean");
    end else begin
      $display("msb_first_field_unpacker_tb: done, errors");
    end
    $finish;
  end

endmodule
